// ===== rtl/rycc_pkg.sv =====
// Shared widths, direction codes and conversion coefficients for the color converter.
`default_nettype none

package rycc_pkg;

	localparam int PIX_W  = 8;
	localparam int OPD_W  = PIX_W + 1;
	localparam int COEF_W = 18;
	localparam int FRAC_W = 16;
	localparam int SUM_W  = 27;
	localparam int NCH    = 3;
	localparam int TDATA_W = NCH * PIX_W;

	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_INV = 1'b1
	} dir_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [OPD_W-1:0] opd_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam opd_t CHROMA_OFF = 9'sd128;

	// Rows are output channels, columns the three operands, 16 fractional bits.
	localparam coef_t FWD_COEF [NCH][NCH] = '{
		'{ 18'sd19595,  18'sd38470,  18'sd7471 },
		'{-18'sd11010, -18'sd21692,  18'sd32768},
		'{ 18'sd32768, -18'sd27440, -18'sd5328 }
	};
	localparam coef_t INV_COEF [NCH][NCH] = '{
		'{ 18'sd65536,  18'sd0,      18'sd91881},
		'{ 18'sd65536, -18'sd22553, -18'sd46802},
		'{ 18'sd65536,  18'sd116130, 18'sd0    }
	};

	// Constant terms include the rounding half; forward chroma adds the 128 offset.
	localparam sum_t HALF_LSB = 27'sd32768;
	localparam sum_t FWD_BIAS [NCH] = '{
		27'sd32768,
		27'sd8421376,
		27'sd8421376
	};
	localparam sum_t INV_BIAS [NCH] = '{
		27'sd32768,
		27'sd32768,
		27'sd32768
	};

endpackage

`default_nettype wire

// ===== rtl/rycc_chan.sv =====
// One output channel: three products, a sum with bias, rounding shift and clamp to 0..255.
`default_nettype none

module rycc_chan (
	input  wire rycc_pkg::opd_t  opd_a,
	input  wire rycc_pkg::opd_t  opd_b,
	input  wire rycc_pkg::opd_t  opd_c,
	input  wire rycc_pkg::coef_t coef_a,
	input  wire rycc_pkg::coef_t coef_b,
	input  wire rycc_pkg::coef_t coef_c,
	input  wire rycc_pkg::sum_t  bias,
	output rycc_pkg::pix_t       result
);

	rycc_pkg::sum_t prod_a;
	rycc_pkg::sum_t prod_b;
	rycc_pkg::sum_t prod_c;
	rycc_pkg::sum_t sum;

	assign prod_a = rycc_pkg::SUM_W'(opd_a) * rycc_pkg::SUM_W'(coef_a);
	assign prod_b = rycc_pkg::SUM_W'(opd_b) * rycc_pkg::SUM_W'(coef_b);
	assign prod_c = rycc_pkg::SUM_W'(opd_c) * rycc_pkg::SUM_W'(coef_c);
	assign sum    = prod_a + prod_b + prod_c + bias;

	// The sum already carries the rounding half, so a plain shift finishes the rounding.
	always_comb begin
		if (sum[rycc_pkg::SUM_W-1]) begin
			result = '0;
		end else if (|sum[rycc_pkg::SUM_W-2:rycc_pkg::FRAC_W+rycc_pkg::PIX_W]) begin
			result = '1;
		end else begin
			result = sum[rycc_pkg::FRAC_W+rycc_pkg::PIX_W-1:rycc_pkg::FRAC_W];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgb_ycbcr_color_converter_unit.sv =====
// RGB to full-range YCbCr converter and back, one 8-bit three-channel pixel per word.
// Path: a word is taken into the input register, then into the result register, from which it is offered.
// Throughput: one word per cycle while the output is not stalled; an input register and a result register hold one
// word each, and the arithmetic of all three channels sits between them.
// Reset: arst_n clears the valid flags and sets the direction to RGB to YCbCr.
`default_nettype none

module rgb_ycbcr_color_converter_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [0:0] cfg_data,       // direction: 0 RGB to YCbCr, 1 YCbCr to RGB
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [23:0] s_axis_tdata,   // in_c0 [7:0], in_c1 [15:8], in_c2 [23:16]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata   // out_c0 [7:0], out_c1 [15:8], out_c2 [23:16]
);

	rycc_pkg::dir_t direction_q;
	rycc_pkg::dir_t dir_s1;
	logic           valid_s1;
	logic           valid_s2;
	logic           ready_s1;
	logic           ready_s2;
	rycc_pkg::pix_t px_s1  [rycc_pkg::NCH];
	rycc_pkg::pix_t res_s2 [rycc_pkg::NCH];
	rycc_pkg::pix_t res    [rycc_pkg::NCH];
	rycc_pkg::opd_t opd    [rycc_pkg::NCH];
	rycc_pkg::coef_t coef  [rycc_pkg::NCH][rycc_pkg::NCH];
	rycc_pkg::sum_t  bias  [rycc_pkg::NCH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= rycc_pkg::DIR_FWD;
		end else if (cfg_valid) begin
			direction_q <= rycc_pkg::dir_t'(cfg_data[0]);
		end
	end

	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			dir_s1 <= direction_q;
			for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
				px_s1[ch] <= s_axis_tdata[ch*rycc_pkg::PIX_W +: rycc_pkg::PIX_W];
			end
		end
		if (ready_s2 && valid_s1) begin
			for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
				res_s2[ch] <= res[ch];
			end
		end
	end

	// In the inverse direction the two chroma operands are centered on zero.
	always_comb begin
		for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
			if (dir_s1 == rycc_pkg::DIR_INV && ch != 0) begin
				opd[ch] = rycc_pkg::opd_t'({1'b0, px_s1[ch]}) - rycc_pkg::CHROMA_OFF;
			end else begin
				opd[ch] = rycc_pkg::opd_t'({1'b0, px_s1[ch]});
			end
			for (int k = 0; k < rycc_pkg::NCH; k++) begin
				coef[ch][k] = (dir_s1 == rycc_pkg::DIR_INV) ? rycc_pkg::INV_COEF[ch][k]
				                                            : rycc_pkg::FWD_COEF[ch][k];
			end
			bias[ch] = (dir_s1 == rycc_pkg::DIR_INV) ? rycc_pkg::INV_BIAS[ch]
			                                         : rycc_pkg::FWD_BIAS[ch];
		end
	end

	for (genvar g = 0; g < rycc_pkg::NCH; g++) begin : g_chan
		rycc_chan u_chan (
			.opd_a  (opd[0]),
			.opd_b  (opd[1]),
			.opd_c  (opd[2]),
			.coef_a (coef[g][0]),
			.coef_b (coef[g][1]),
			.coef_c (coef[g][2]),
			.bias   (bias[g]),
			.result (res[g])
		);
	end

	assign m_axis_tvalid = valid_s2;

	always_comb begin
		for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
			m_axis_tdata[ch*rycc_pkg::PIX_W +: rycc_pkg::PIX_W] = res_s2[ch];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rycc_checker.sv =====
// Port-level checks for the color converter, bound to the top level.
`default_nettype none

module rycc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata
);

	// Nothing is offered on the output while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output word valid during reset");

	// A word accepted with a free path passes the input and result registers and then shows on the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted word did not reach the output in time");

	// A stalled output word stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word withdrawn while stalled");

	// A stalled output word keeps its value.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

endmodule

bind rgb_ycbcr_color_converter_unit rycc_checker u_rycc_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking stream testbench for the RGB and full-range YCbCr pixel converter.
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY = 2;
	localparam int RAND_PER_PHASE = 175;

	typedef logic [rycc_pkg::NCH-1:0][rycc_pkg::PIX_W-1:0] px_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic  [0:0] cfg_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;    // in_c0 [7:0], in_c1 [15:8], in_c2 [23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // out_c0 [7:0], out_c1 [15:8], out_c2 [23:16]

	px_t  pixel_q[$];       // words waiting to be sent
	px_t  converted_q[$];   // predicted output words, oldest first
	rycc_pkg::dir_t dir_now = rycc_pkg::DIR_FWD;
	int   fail_count = 0;
	logic in_fire = 1'b0;
	int   src_gap = 0;
	int   snk_gap = 0;
	bit   src_idle_on = 1'b1;
	bit   snk_idle_on = 1'b1;

	rgb_ycbcr_color_converter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Sum with 16 fractional bits, rounded half up and saturated to a byte.
	function automatic rycc_pkg::pix_t round_sat(int s);
		int t;
		t = s + 32768;
		if (t < 0)
			return '0;
		t = t >>> 16;
		if (t > 255)
			return 8'd255;
		return t[7:0];
	endfunction

	function automatic px_t convert_pixel(rycc_pkg::dir_t dir, px_t p);
		int a, b, c;
		px_t r;
		a = p[0];
		b = p[1];
		c = p[2];
		if (dir == rycc_pkg::DIR_FWD) begin
			r[0] = round_sat(19595 * a + 38470 * b + 7471 * c);
			r[1] = round_sat(-11010 * a - 21692 * b + 32768 * c + 128 * 65536);
			r[2] = round_sat(32768 * a - 27440 * b - 5328 * c + 128 * 65536);
		end else begin
			b = b - 128;
			c = c - 128;
			r[0] = round_sat(65536 * a + 91881 * c);
			r[1] = round_sat(65536 * a - 22553 * b - 46802 * c);
			r[2] = round_sat(65536 * a + 116130 * b);
		end
		return r;
	endfunction

	function automatic px_t mk_px(int c0, int c1, int c2);
		px_t p;
		p[0] = c0[7:0];
		p[1] = c1[7:0];
		p[2] = c2[7:0];
		return p;
	endfunction

	// Mostly uniform channels; some lean on the ends of the range to reach the clamps.
	function automatic rycc_pkg::pix_t rand_chan();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return rycc_pkg::pix_t'($urandom_range(0, 255));
		else if (r < 85)
			return rycc_pkg::pix_t'($urandom_range(0, 6));
		return rycc_pkg::pix_t'($urandom_range(249, 255));
	endfunction

	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Source side: a word is held until the edge that takes it.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				src_idle_on = !src_idle_on;
			if (!s_axis_tvalid || in_fire) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					s_axis_tdata <= pixel_q.pop_front();
					s_axis_tvalid <= 1'b1;
					src_gap = pick_gap(src_idle_on);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				snk_idle_on = !snk_idle_on;
			if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				snk_gap = pick_gap(snk_idle_on);
			end
		end
	end

	always @(posedge clk) begin : monitor
		px_t want, got;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				dir_now = rycc_pkg::dir_t'(cfg_data[0]);
			if (s_axis_tvalid && s_axis_tready)
				converted_q.push_back(convert_pixel(dir_now, px_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = px_t'(m_axis_tdata);
				if (converted_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h", $time, got);
					fail_count++;
				end else begin
					want = converted_q.pop_front();
					for (int ch = 0; ch < rycc_pkg::NCH; ch++) begin
						if (got[ch] !== want[ch]) begin
							$display("%0t: out_c%0d expected %0d, got %0d",
								$time, ch, want[ch], got[ch]);
							fail_count++;
						end
					end
				end
			end
		end
	end

	// The sender holds off here until every predicted word has come out.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || s_axis_tvalid || converted_q.size() != 0);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic set_direction(rycc_pkg::dir_t d);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		rycc_pkg::dir_t phase_dir;
		// Driven at time zero so that the asynchronous reset sees a falling edge.
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Forward after reset: black, white, the primaries and the secondaries.
		pixel_q.push_back(mk_px(0, 0, 0));
		pixel_q.push_back(mk_px(255, 255, 255));
		pixel_q.push_back(mk_px(255, 0, 0));
		pixel_q.push_back(mk_px(0, 255, 0));
		pixel_q.push_back(mk_px(0, 0, 255));
		pixel_q.push_back(mk_px(255, 255, 0));
		pixel_q.push_back(mk_px(0, 255, 255));
		pixel_q.push_back(mk_px(255, 0, 255));

		// Inverse: extreme chroma drives every channel into both clamps.
		set_direction(rycc_pkg::DIR_INV);
		pixel_q.push_back(mk_px(0, 0, 0));
		pixel_q.push_back(mk_px(255, 255, 255));
		pixel_q.push_back(mk_px(128, 128, 128));
		pixel_q.push_back(mk_px(0, 255, 0));
		pixel_q.push_back(mk_px(255, 0, 255));
		pixel_q.push_back(mk_px(0, 255, 255));
		pixel_q.push_back(mk_px(255, 0, 0));
		pixel_q.push_back(mk_px(16, 240, 16));
		pixel_q.push_back(mk_px(235, 16, 240));
		pixel_q.push_back(mk_px(0, 128, 255));

		phase_dir = rycc_pkg::DIR_FWD;
		for (int ph = 0; ph < 4; ph++) begin
			set_direction(phase_dir);
			for (int k = 0; k < RAND_PER_PHASE; k++)
				pixel_q.push_back(mk_px(rand_chan(), rand_chan(), rand_chan()));
			phase_dir = (phase_dir == rycc_pkg::DIR_FWD) ? rycc_pkg::DIR_INV
			                                             : rycc_pkg::DIR_FWD;
		end

		wait_idle();
		repeat (2 * LATENCY + 4) @(posedge clk);
		if (fail_count == 0 && converted_q.size() == 0) begin
			$display("rgb_ycbcr_color_converter_unit regression: pass");
		end else begin
			$display("rgb_ycbcr_color_converter_unit regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("rgb_ycbcr_color_converter_unit regression: fail");
		$finish;
	end

endmodule
